>>> sv/assert_macros.svh
// Assertion macros shared by the average-pool window unit RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define APW_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define APW_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/apw_pkg.sv
// Shared constants, types and the divisor reciprocal table for the average-pool unit.
// No dependencies; imported by every module of the block.
package apw_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_WINDOW  = 8;
  localparam int PIXEL_BITS  = 16;
  localparam int ROW_LIMIT   = 1024;

  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int DIM_W       = COL_W + 1;
  localparam int KCFG_W      = 4;
  localparam int RING_W      = $clog2(MAX_WINDOW);
  localparam int CSUM_W      = PIXEL_BITS + RING_W;
  localparam int WSUM_W      = CSUM_W + RING_W;
  // floor(n/d) == (n * ceil(2^RSHIFT/d)) >> RSHIFT for n < 2^WSUM_W, d <= MAX_WINDOW^2
  localparam int RSHIFT      = WSUM_W + 2 * RING_W;
  localparam int RECIP_W     = RSHIFT + 1;
  localparam int PROD_W      = WSUM_W + RECIP_W;
  localparam int LS_AW       = RING_W + COL_W;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = DIM_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [DIM_W-1:0]  WIDTH_RESET  = DIM_W'(1024);
  localparam logic [DIM_W-1:0]  HEIGHT_RESET = DIM_W'(1024);
  localparam logic [KCFG_W-1:0] WINDOW_RESET = KCFG_W'(8);
  localparam logic [KCFG_W-1:0] STRIDE_RESET = KCFG_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_WINDOW_SIZE  = 2'd2,
    CFG_STRIDE       = 2'd3
  } cfg_reg_t;

  // One classified pixel, handed from the front end to the back end
  typedef struct packed {
    logic [PIXEL_BITS-1:0] pix;
    logic [COL_W-1:0]      ci;
    logic [RING_W-1:0]     rslot;
    logic [RING_W-1:0]     ring;
    logic                  row_first;
    logic                  row_fill;
    logic                  col_first;
    logic                  col_fill;
    logic                  emit;
    logic [COL_W-1:0]      orow;
    logic [COL_W-1:0]      ocol;
    logic                  last;
    logic [RING_W-1:0]     kidx;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_MUL,
    BK_OUT
  } back_state_t;

  // ceil(2^RSHIFT / k^2), indexed by k-1
  function automatic logic [RECIP_W-1:0] recip(input logic [RING_W-1:0] kidx);
    logic [RECIP_W-1:0] m;
    case (kidx)
      3'd0:    m = RECIP_W'(268435456);
      3'd1:    m = RECIP_W'(67108864);
      3'd2:    m = RECIP_W'(29826162);
      3'd3:    m = RECIP_W'(16777216);
      3'd4:    m = RECIP_W'(10737419);
      3'd5:    m = RECIP_W'(7456541);
      3'd6:    m = RECIP_W'(5478275);
      3'd7:    m = RECIP_W'(4194304);
      default: m = RECIP_W'(4194304);
    endcase
    return m;
  endfunction

endpackage

>>> sv/apw_front.sv
// Front end: configuration registers, raster position counters and window classification.
// Depends on apw_pkg; feeds apw_queue.
module apw_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [apw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [apw_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             pixel_valid,
  output logic                             pixel_stall,
  input  logic [apw_pkg::PIXEL_BITS-1:0]   pixel,
  input  logic                             q_full,
  output logic                             q_push,
  output apw_pkg::cmd_t                    q_cmd
);
  import apw_pkg::*;

  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [KCFG_W-1:0] window_size;
  logic [KCFG_W-1:0] stride;

  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic [KCFG_W-1:0] k_eff;
  logic [KCFG_W-1:0] s_eff;
  logic [KCFG_W-1:0] s_last;
  logic [RING_W-1:0] km1;
  logic [DIM_W-1:0]  k_ext;

  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  row;
  logic [RING_W-1:0] cring;
  logic [RING_W-1:0] rring;
  logic [KCFG_W-1:0] cph;
  logic [KCFG_W-1:0] rph;
  logic [COL_W-1:0]  ocol;
  logic [COL_W-1:0]  orow;

  logic [DIM_W-1:0]  c1;
  logic [DIM_W-1:0]  r1;
  logic              col_in;
  logic              row_in;
  logic              col_hit;
  logic              row_hit;
  logic              col_wrap;
  logic              row_wrap;
  logic              col_last;
  logic              row_last;
  logic              accept;
  logic              cfg_we;
  logic              cfg_hit;

  assign cfg_ready   = 1'b1;
  assign cfg_we      = cfg_valid && cfg_ready;
  assign pixel_stall = q_full;
  assign accept      = pixel_valid && !q_full;
  assign q_push      = accept;

  always_comb begin
    case (cfg_reg_t'(cfg_index))
      CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_WINDOW_SIZE, CFG_STRIDE: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      window_size  <= WINDOW_RESET;
      stride       <= STRIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        CFG_WINDOW_SIZE:  window_size  <= cfg_data[KCFG_W-1:0];
        CFG_STRIDE:       stride       <= cfg_data[KCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Registers are used clamped to their legal ranges
  always_comb begin
    if (image_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (image_width > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (image_height > DIM_W'(ROW_LIMIT)) begin
      h_eff = DIM_W'(ROW_LIMIT);
    end else begin
      h_eff = image_height;
    end
    if (window_size == '0) begin
      k_eff = KCFG_W'(1);
    end else if (window_size > KCFG_W'(MAX_WINDOW)) begin
      k_eff = KCFG_W'(MAX_WINDOW);
    end else begin
      k_eff = window_size;
    end
    s_eff = (stride == '0) ? KCFG_W'(1) : stride;
  end

  assign s_last = s_eff - KCFG_W'(1);
  assign km1    = RING_W'(k_eff - KCFG_W'(1));
  assign k_ext  = DIM_W'(k_eff);

  assign c1       = {1'b0, col} + DIM_W'(1);
  assign r1       = {1'b0, row} + DIM_W'(1);
  assign col_in   = c1 >= k_ext;
  assign row_in   = r1 >= k_ext;
  assign col_hit  = col_in && (cph == '0);
  assign row_hit  = row_in && (rph == '0);
  assign col_wrap = c1 >= w_eff;
  assign row_wrap = r1 >= h_eff;
  // last window of a row/column: the next origin along would overhang the edge
  assign col_last = ({1'b0, c1} + (DIM_W+1)'(s_eff)) > {1'b0, w_eff};
  assign row_last = ({1'b0, r1} + (DIM_W+1)'(s_eff)) > {1'b0, h_eff};

  always_comb begin
    q_cmd.pix       = pixel;
    q_cmd.ci        = col;
    q_cmd.rslot     = rring;
    q_cmd.ring      = cring;
    q_cmd.row_first = (row == '0);
    q_cmd.row_fill  = ({1'b0, row} < k_ext);
    q_cmd.col_first = (col == '0);
    q_cmd.col_fill  = ({1'b0, col} < k_ext);
    q_cmd.emit      = col_hit && row_hit;
    q_cmd.orow      = orow;
    q_cmd.ocol      = ocol;
    q_cmd.last      = col_last && row_last;
    q_cmd.kidx      = km1;
  end

  always_ff @(posedge clk) begin
    if (rst || (cfg_we && cfg_hit)) begin
      col   <= '0;
      row   <= '0;
      cring <= '0;
      rring <= '0;
      cph   <= '0;
      rph   <= '0;
      ocol  <= '0;
      orow  <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col   <= '0;
        cring <= '0;
        cph   <= '0;
        ocol  <= '0;
        if (row_wrap) begin
          row   <= '0;
          rring <= '0;
          rph   <= '0;
          orow  <= '0;
        end else begin
          row   <= row + COL_W'(1);
          rring <= (rring == km1) ? '0 : rring + RING_W'(1);
          if (row_in) begin
            rph <= (rph == s_last) ? '0 : rph + KCFG_W'(1);
          end
          if (row_hit) begin
            orow <= orow + COL_W'(1);
          end
        end
      end else begin
        col   <= col + COL_W'(1);
        cring <= (cring == km1) ? '0 : cring + RING_W'(1);
        if (col_in) begin
          cph <= (cph == s_last) ? '0 : cph + KCFG_W'(1);
        end
        if (col_hit) begin
          ocol <= ocol + COL_W'(1);
        end
      end
    end
  end

endmodule

>>> sv/apw_queue.sv
// Short command queue between front and back ends of the average-pool unit.
// Depends on apw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module apw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  apw_pkg::cmd_t push_cmd,
  input  logic          pop,
  output apw_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import apw_pkg::*;

  cmd_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  `APW_ASSERT_IMP(a_no_push_full, clk, rst, full, !push, "push into full queue")
  `APW_ASSERT_IMP(a_no_pop_empty, clk, rst, empty, !pop, "pop from empty queue")
  `APW_ASSERT_NEXT(a_count_push, clk, rst, push && !pop, count == $past(count) + 3'd1, "queue count did not rise on push")

endmodule

>>> sv/apw_back.sv
// Back end: line store and column-sum memories, horizontal running sum,
// reciprocal divide and the result register. Depends on apw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module apw_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_empty,
  input  apw_pkg::cmd_t                   q_head,
  output logic                            q_pop,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [apw_pkg::PIXEL_BITS-1:0]  average,
  output logic [apw_pkg::COL_W-1:0]       out_row,
  output logic [apw_pkg::COL_W-1:0]       out_col,
  output logic                            frame_last
);
  import apw_pkg::*;

  back_state_t state;
  back_state_t state_next;

  cmd_t                  cur;
  logic [PIXEL_BITS-1:0] line_store  [2**LS_AW];
  logic [CSUM_W-1:0]     column_sums [MAX_WIDTH];
  logic [CSUM_W-1:0]     recent      [MAX_WINDOW];
  logic [PIXEL_BITS-1:0] ls_rdata;
  logic [CSUM_W-1:0]     cs_rdata;
  logic [WSUM_W-1:0]     window_sum;
  logic [PROD_W-1:0]     prod;

  logic [LS_AW-1:0]      rd_addr;
  logic [LS_AW-1:0]      wr_addr;
  logic [CSUM_W-1:0]     cs;
  logic [WSUM_W-1:0]     ws;
  logic                  mem_wr;
  logic                  mul_en;
  logic                  load;
  logic                  out_free;

  assign rd_addr  = {q_head.rslot, q_head.ci};
  assign wr_addr  = {cur.rslot, cur.ci};
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    case (state)
      BK_IDLE: state_next = q_empty ? BK_IDLE : BK_EXEC;
      BK_EXEC: state_next = cur.emit ? BK_MUL : BK_IDLE;
      BK_MUL:  state_next = BK_OUT;
      BK_OUT:  state_next = out_free ? BK_IDLE : BK_OUT;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop  = (state == BK_IDLE) && !q_empty;
    mem_wr = (state == BK_EXEC);
    mul_en = (state == BK_MUL);
    load   = (state == BK_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      line_store[wr_addr] <= cur.pix;
    end
    if (q_pop) begin
      ls_rdata <= line_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      column_sums[cur.ci] <= cs;
    end
    if (q_pop) begin
      cs_rdata <= column_sums[q_head.ci];
    end
  end

  // Vertical sum of the last k rows in this column
  always_comb begin
    if (cur.row_first) begin
      cs = CSUM_W'(cur.pix);
    end else if (cur.row_fill) begin
      cs = cs_rdata + CSUM_W'(cur.pix);
    end else begin
      cs = cs_rdata + CSUM_W'(cur.pix) - CSUM_W'(ls_rdata);
    end
  end

  // Horizontal sum of the last k column sums
  always_comb begin
    if (cur.col_first) begin
      ws = WSUM_W'(cs);
    end else if (cur.col_fill) begin
      ws = window_sum + WSUM_W'(cs);
    end else begin
      ws = window_sum + WSUM_W'(cs) - WSUM_W'(recent[cur.ring]);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      recent[cur.ring] <= cs;
      window_sum       <= ws;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= PROD_W'(window_sum) * PROD_W'(recip(cur.kidx));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      average    <= prod[RSHIFT +: PIXEL_BITS];
      out_row    <= cur.orow;
      out_col    <= cur.ocol;
      frame_last <= cur.last;
    end
  end

  `APW_ASSERT_NEXT(a_mul_to_out, clk, rst, state == BK_MUL, state == BK_OUT, "multiply not followed by output stage")
  `APW_ASSERT_IMP(a_load_emit, clk, rst, load, cur.emit, "result loaded for a non-emitting pixel")
  `APW_ASSERT_IMP(a_pop_idle, clk, rst, q_pop, state == BK_IDLE, "queue popped outside idle")

endmodule

>>> sv/average_pool_2d_window_unit.sv
// From pixel transaction to result valid when the queue is empty: queue entry, then the
// back end's idle, execute, multiply and output states; a pixel that emits no result
// ends at execute; output waits while the result register is stalled. Pixels are taken
// singly, paced by the line store and column-sum read-then-write and reciprocal multiply.
// Reset: registers return to 1024 x 1024, window 8, stride 2; counters and queue clear;
// memories need no clearing pass as no entry is used in a frame before it is written.
module average_pool_2d_window_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [apw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [apw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            pixel_valid,
  output logic                            pixel_stall,
  input  logic [apw_pkg::PIXEL_BITS-1:0]  pixel,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [apw_pkg::PIXEL_BITS-1:0]  average,
  output logic [apw_pkg::COL_W-1:0]       out_row,
  output logic [apw_pkg::COL_W-1:0]       out_col,
  output logic                            frame_last
);
  import apw_pkg::*;

  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic full;
  logic empty;

  apw_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .q_full      (full),
    .q_push      (push),
    .q_cmd       (push_cmd)
  );

  apw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  apw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (empty),
    .q_head       (head),
    .q_pop        (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .average      (average),
    .out_row      (out_row),
    .out_col      (out_col),
    .frame_last   (frame_last)
  );

endmodule
